[rtl/qbt_pkg.sv]
// Shared types and constants for the quadratic Bezier tessellator.
// Holds field widths, the sample-to-t table and the register index codes.
// No dependencies; compiled before every other file.
`timescale 1ns / 1ps

package qbt_pkg;

    // Number of curve segments; t = index / SEGMENTS
    localparam int SEGMENTS = 128;

    // Field widths
    localparam int IDX_W     = 7;
    localparam int IDX_DEPTH = 2 ** IDX_W;
    localparam int Q_W       = 24;          // signed Q15.8 coordinate
    localparam int T_W       = 17;          // Q0.16 parameter, 1.0 included
    localparam int W_W       = 33;          // blend weight, up to 2^32
    localparam int P_W       = 58;          // signed weight * coordinate
    localparam int CFG_IDX_W = 3;

    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    // Last sample flag only fires when SEGMENTS-1 fits in the index field
    localparam bit               LAST_REACHABLE = (SEGMENTS - 1) < IDX_DEPTH;
    localparam logic [IDX_W-1:0] LAST_IDX       = IDX_W'(SEGMENTS - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_CTRL_X  = 3'd2,
        CFG_CTRL_Y  = 3'd3,
        CFG_END_X   = 3'd4,
        CFG_END_Y   = 3'd5,
        CFG_APEX_X  = 3'd6,
        CFG_APEX_Y  = 3'd7
    } t_cfg_reg;

    // Stage enables handed to the per-axis datapath
    typedef struct packed {
        logic mul;
        logic sum;
        logic rnd;
    } t_axis_en;

    typedef logic [T_W-1:0] t_t_lut [IDX_DEPTH];

    // t = round(i * 65536 / SEGMENTS), index saturated to SEGMENTS-1
    function automatic t_t_lut build_t_lut();
        t_t_lut          lut;
        int unsigned     k;
        int unsigned     i;
        longint unsigned v;
        for (k = 0; k < IDX_DEPTH; k++) begin
            i = (k > SEGMENTS - 1) ? SEGMENTS - 1 : k;
            v = (longint'(i) * 65536 + SEGMENTS / 2) / SEGMENTS;
            if (v > 65536) begin
                v = 65536;
            end
            lut[k] = T_W'(v);
        end
        return lut;
    endfunction

    localparam t_t_lut T_LUT = build_t_lut();

endpackage

[rtl/qbt_in_if.sv]
// Input channel of the tessellator: one sample request per transaction.
// Depends on qbt_pkg for field widths.
`timescale 1ns / 1ps

interface qbt_in_if;
    logic                        valid;
    logic                        ready;
    logic [qbt_pkg::IDX_W-1:0]   sample_index;
    logic                        lower_half;
    logic                        mirrored;

    modport source (output valid, sample_index, lower_half, mirrored, input ready);
    modport sink   (input valid, sample_index, lower_half, mirrored, output ready);
endinterface

[rtl/qbt_out_if.sv]
// Output channel of the tessellator: one curve point per transaction.
// Depends on qbt_pkg for field widths.
`timescale 1ns / 1ps

interface qbt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [qbt_pkg::Q_W-1:0]     point_x;
    logic signed [qbt_pkg::Q_W-1:0]     point_y;
    logic                               back_region;
    logic                               last_sample;

    modport source (output valid, point_x, point_y, back_region, last_sample, input ready);
    modport sink   (input valid, point_x, point_y, back_region, last_sample, output ready);
endinterface

[rtl/quad_bezier_tessellator_core.sv]
// Quadratic Bezier tessellator: streams curve points and back-region flags.
// Depends on qbt_pkg, qbt_in_if, qbt_out_if and qbt_axis.
//
// Usage:
//   i_sample carries one sample request per transaction (sample_index,
//   lower_half, mirrored). o_point returns one result per request in the
//   same order: point_x, point_y (signed Q15.8), back_region, last_sample.
//   i_cfg_we / i_cfg_idx / i_cfg_wdata write the eight point registers
//   (start, control, end, apex; x then y); write them only while idle.
// Throughput: one transaction per clock while o_point.ready is high;
//   every stage has its own valid bit and enable, so a bubble anywhere
//   is squeezed out. Stages: t lookup, weight multiply, coordinate
//   multiply, sum, round/clamp, compare. The depth is set by the two
//   chained multiplies and the 58-bit sum.
// Reset: synchronous active low; clears all valid bits and the point
//   registers to zero. The block is ready in the cycle after reset.
// Backpressure: when o_point.ready is low, the output holds and each
//   stage stalls only once the stage after it is full; nothing is lost
//   or repeated.
`timescale 1ns / 1ps

module quad_bezier_tessellator_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    qbt_in_if.sink                                i_sample,
    qbt_out_if.source                             o_point,
    input  logic                                  i_cfg_we,
    input  logic [qbt_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [qbt_pkg::Q_W-1:0]               i_cfg_wdata
);

    // Configuration registers
    logic signed [qbt_pkg::Q_W-1:0] r_start_x, r_start_y, r_ctrl_x, r_ctrl_y;
    logic signed [qbt_pkg::Q_W-1:0] r_end_x, r_end_y, r_apex_x, r_apex_y;

    // Stage valid bits (a: t, b: weights, c: products, d: sum, e: round, f: out)
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid, r_f_valid;
    logic w_en_a, w_en_b, w_en_c, w_en_d, w_en_e, w_en_f;

    // Sideband flags travelling with each item
    logic r_a_lower, r_b_lower, r_c_lower, r_d_lower, r_e_lower;
    logic r_a_mirr,  r_b_mirr,  r_c_mirr,  r_d_mirr,  r_e_mirr;
    logic r_a_last,  r_b_last,  r_c_last,  r_d_last,  r_e_last;

    logic [qbt_pkg::T_W-1:0]        r_a_t, r_a_u;
    logic [2*qbt_pkg::T_W-1:0]      n_uu, n_ut, n_tt;
    logic [qbt_pkg::W_W-1:0]        r_b_w0, r_b_w1, r_b_w2;
    logic signed [qbt_pkg::Q_W-1:0] w_x, w_y;
    logic                           n_back;

    logic signed [qbt_pkg::Q_W-1:0] r_f_x, r_f_y;
    logic                           r_f_back, r_f_last;

    qbt_pkg::t_axis_en w_axis_en;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_ctrl_x  <= '0;
            r_ctrl_y  <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
            r_apex_x  <= '0;
            r_apex_y  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                qbt_pkg::CFG_START_X: r_start_x <= i_cfg_wdata;
                qbt_pkg::CFG_START_Y: r_start_y <= i_cfg_wdata;
                qbt_pkg::CFG_CTRL_X:  r_ctrl_x  <= i_cfg_wdata;
                qbt_pkg::CFG_CTRL_Y:  r_ctrl_y  <= i_cfg_wdata;
                qbt_pkg::CFG_END_X:   r_end_x   <= i_cfg_wdata;
                qbt_pkg::CFG_END_Y:   r_end_y   <= i_cfg_wdata;
                qbt_pkg::CFG_APEX_X:  r_apex_x  <= i_cfg_wdata;
                qbt_pkg::CFG_APEX_Y:  r_apex_y  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage advances when empty or when the next one advances
    assign w_en_f = !r_f_valid || o_point.ready;
    assign w_en_e = !r_e_valid || w_en_f;
    assign w_en_d = !r_d_valid || w_en_e;
    assign w_en_c = !r_c_valid || w_en_d;
    assign w_en_b = !r_b_valid || w_en_c;
    assign w_en_a = !r_a_valid || w_en_b;

    assign i_sample.ready = w_en_a;

    assign w_axis_en.mul = w_en_c;
    assign w_axis_en.sum = w_en_d;
    assign w_axis_en.rnd = w_en_e;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            if (w_en_a) r_a_valid <= i_sample.valid;
            if (w_en_b) r_b_valid <= r_a_valid;
            if (w_en_c) r_c_valid <= r_b_valid;
            if (w_en_d) r_d_valid <= r_c_valid;
            if (w_en_e) r_e_valid <= r_d_valid;
            if (w_en_f) r_f_valid <= r_e_valid;
        end
    end

    // Stage a: look up t and its complement, capture the flags
    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_t     <= qbt_pkg::T_LUT[i_sample.sample_index];
            r_a_u     <= qbt_pkg::T_ONE - qbt_pkg::T_LUT[i_sample.sample_index];
            r_a_lower <= i_sample.lower_half;
            r_a_mirr  <= i_sample.mirrored;
            r_a_last  <= qbt_pkg::LAST_REACHABLE
                         && (i_sample.sample_index == qbt_pkg::LAST_IDX);
        end
    end

    // Stage b: blend weights u^2, 2ut, t^2 (they sum to 2^32)
    assign n_uu = r_a_u * r_a_u;
    assign n_ut = r_a_u * r_a_t;
    assign n_tt = r_a_t * r_a_t;

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            r_b_w0    <= n_uu[qbt_pkg::W_W-1:0];
            r_b_w1    <= {n_ut[qbt_pkg::W_W-2:0], 1'b0};
            r_b_w2    <= n_tt[qbt_pkg::W_W-1:0];
            r_b_lower <= r_a_lower;
            r_b_mirr  <= r_a_mirr;
            r_b_last  <= r_a_last;
        end
    end

    // Stages c, d, e: per-axis multiply, sum and round
    qbt_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (w_axis_en),
        .i_w0    (r_b_w0),
        .i_w1    (r_b_w1),
        .i_w2    (r_b_w2),
        .i_a     (r_start_x),
        .i_b     (r_ctrl_x),
        .i_c     (r_end_x),
        .o_coord (w_x)
    );

    qbt_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (w_axis_en),
        .i_w0    (r_b_w0),
        .i_w1    (r_b_w1),
        .i_w2    (r_b_w2),
        .i_a     (r_start_y),
        .i_b     (r_ctrl_y),
        .i_c     (r_end_y),
        .o_coord (w_y)
    );

    // Carry the flags alongside the axis stages
    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            r_c_lower <= r_b_lower;
            r_c_mirr  <= r_b_mirr;
            r_c_last  <= r_b_last;
        end
        if (w_en_d) begin
            r_d_lower <= r_c_lower;
            r_d_mirr  <= r_c_mirr;
            r_d_last  <= r_c_last;
        end
        if (w_en_e) begin
            r_e_lower <= r_d_lower;
            r_e_mirr  <= r_d_mirr;
            r_e_last  <= r_d_last;
        end
    end

    // Stage f: back-region test against the apex, strict compares
    always_comb begin
        if (r_e_lower) begin
            n_back = (w_y > r_apex_y) && (r_e_mirr ? (w_x < r_apex_x) : (w_x > r_apex_x));
        end else begin
            n_back = (w_y < r_apex_y) && (r_e_mirr ? (w_x > r_apex_x) : (w_x < r_apex_x));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_f) begin
            r_f_x    <= w_x;
            r_f_y    <= w_y;
            r_f_back <= n_back;
            r_f_last <= r_e_last;
        end
    end

    assign o_point.valid       = r_f_valid;
    assign o_point.point_x     = r_f_x;
    assign o_point.point_y     = r_f_y;
    assign o_point.back_region = r_f_back;
    assign o_point.last_sample = r_f_last;

`ifndef ASSERT_OFF
    // An empty output stage never blocks the input
    a_ready_when_drained: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_f_valid |-> i_sample.ready
    ) else $error("input stalled with empty output stage");

    // Occupancy changes only by transactions at the two ends
    a_occupancy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones({r_a_valid, r_b_valid, r_c_valid,
                              r_d_valid, r_e_valid, r_f_valid})
                  == $past($countones({r_a_valid, r_b_valid, r_c_valid,
                                       r_d_valid, r_e_valid, r_f_valid}))
                     + int'($past(i_sample.valid && i_sample.ready))
                     - int'($past(o_point.valid && o_point.ready)))
    ) else $error("pipeline dropped or duplicated an item");

    // A stalled round stage keeps its item
    a_round_stage_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && !w_en_e) |=> r_e_valid
    ) else $error("round stage lost an item under stall");

    // A full pipeline blocks the input while the receiver stalls
    a_full_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_b_valid && r_c_valid && r_d_valid && r_e_valid
         && r_f_valid && !o_point.ready) |-> !i_sample.ready
    ) else $error("input accepted into a full pipeline");
`endif

endmodule

[rtl/qbt_axis.sv]
// One coordinate of the curve: weighted blend of three control values,
// rounded to nearest and saturated to Q15.8. Three register stages.
// Depends on qbt_pkg.
`timescale 1ns / 1ps

module qbt_axis (
    input  logic                               i_clk,
    input  qbt_pkg::t_axis_en                  i_en,
    input  logic        [qbt_pkg::W_W-1:0]     i_w0,
    input  logic        [qbt_pkg::W_W-1:0]     i_w1,
    input  logic        [qbt_pkg::W_W-1:0]     i_w2,
    input  logic signed [qbt_pkg::Q_W-1:0]     i_a,
    input  logic signed [qbt_pkg::Q_W-1:0]     i_b,
    input  logic signed [qbt_pkg::Q_W-1:0]     i_c,
    output logic signed [qbt_pkg::Q_W-1:0]     o_coord
);

    localparam int RND_W = qbt_pkg::P_W - 32;

    logic signed [qbt_pkg::P_W-1:0] r_p0, r_p1, r_p2;
    logic signed [qbt_pkg::P_W-1:0] r_acc;
    logic signed [qbt_pkg::P_W-1:0] n_biased;
    logic signed [RND_W-1:0]        n_q;
    logic signed [qbt_pkg::Q_W-1:0] n_coord;
    logic signed [qbt_pkg::Q_W-1:0] r_coord;

    // Multiply each weight by its control value
    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_p0 <= qbt_pkg::P_W'($signed({1'b0, i_w0}) * i_a);
            r_p1 <= qbt_pkg::P_W'($signed({1'b0, i_w1}) * i_b);
            r_p2 <= qbt_pkg::P_W'($signed({1'b0, i_w2}) * i_c);
        end
    end

    // Sum the three products
    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_acc <= r_p0 + r_p1 + r_p2;
        end
    end

    // Round half up to Q15.8, then clamp to the 24-bit range
    always_comb begin
        n_biased = r_acc + qbt_pkg::P_W'(64'sd2147483648);
        n_q      = n_biased[qbt_pkg::P_W-1:32];
        if (n_q > RND_W'(32'sd8388607)) begin
            n_coord = 24'sh7FFFFF;
        end else if (n_q < -RND_W'(32'sd8388608)) begin
            n_coord = 24'sh800000;
        end else begin
            n_coord = n_q[qbt_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.rnd) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

[test/quad_bezier_tessellator_core_test.sv]
// Self-checking testbench for quad_bezier_tessellator_core: directed table, then random phases.
// Predicts every curve point and back-region flag and checks results in order.
// Depends on qbt_pkg, qbt_in_if, qbt_out_if and the core RTL.
`timescale 1ns / 1ps

module quad_bezier_tessellator_core_test;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 155;
    localparam int HOLD_CYCLES   = 150;

    localparam logic signed [qbt_pkg::Q_W-1:0] COORD_MAX =
        qbt_pkg::Q_W'((1 <<< (qbt_pkg::Q_W - 1)) - 1);
    localparam logic signed [qbt_pkg::Q_W-1:0] COORD_MIN =
        qbt_pkg::Q_W'(-(1 <<< (qbt_pkg::Q_W - 1)));

    typedef struct {
        logic signed [qbt_pkg::Q_W-1:0] x;
        logic signed [qbt_pkg::Q_W-1:0] y;
        logic                           back;
        logic                           last;
    } t_curve_point;

    // One directed row: register set, request fields, and a typed point where obvious
    typedef struct {
        int                             cfg_set;
        logic [qbt_pkg::IDX_W-1:0]      idx;
        bit                             lower;
        bit                             mirr;
        bit                             typed;
        logic signed [qbt_pkg::Q_W-1:0] x;
        logic signed [qbt_pkg::Q_W-1:0] y;
        bit                             back;
        bit                             last;
    } t_sample_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [qbt_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [qbt_pkg::Q_W-1:0]       cfg_wdata;

    qbt_in_if  sample_bus ();
    qbt_out_if point_bus ();

    quad_bezier_tessellator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (sample_bus),
        .o_point     (point_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Register sets for the directed part, in register index order:
    // start x/y, control x/y, end x/y, apex x/y
    logic signed [qbt_pkg::Q_W-1:0] curve_sets [5][8] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0},
        '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0},
        '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 0, 0},
        '{-256, 512, 1000, -3000, -77777, 123456, COORD_MIN, COORD_MAX}
    };

    t_sample_row sample_rows [20] = '{
        // reset registers: every point is the origin, never strictly past the apex
        '{0,   0, 0, 0, 1, 0, 0, 0, 0},
        '{0, 127, 1, 1, 1, 0, 0, 0, 1},
        '{0,  64, 0, 1, 1, 0, 0, 0, 0},
        '{0,   1, 1, 0, 1, 0, 0, 0, 0},
        // all points at the positive extreme, apex at the origin
        '{1,   0, 1, 0, 1, COORD_MAX, COORD_MAX, 1, 0},
        '{1, 127, 0, 0, 1, COORD_MAX, COORD_MAX, 0, 1},
        '{1,  64, 1, 1, 1, COORD_MAX, COORD_MAX, 0, 0},
        '{1,   5, 0, 1, 1, COORD_MAX, COORD_MAX, 0, 0},
        // all points at the negative extreme
        '{2,   0, 0, 0, 1, COORD_MIN, COORD_MIN, 1, 0},
        '{2, 127, 1, 0, 1, COORD_MIN, COORD_MIN, 0, 1},
        '{2, 100, 1, 1, 1, COORD_MIN, COORD_MIN, 0, 0},
        '{2,  33, 0, 1, 1, COORD_MIN, COORD_MIN, 0, 0},
        // opposite extremes between start and the other points
        '{3,   0, 0, 1, 1, COORD_MAX, COORD_MIN, 1, 0},
        '{3,  64, 1, 0, 0, 0, 0, 0, 0},
        '{3, 127, 1, 1, 0, 0, 0, 0, 0},
        '{3,  32, 0, 0, 0, 0, 0, 0, 0},
        // ordinary curve against an apex at the range corners
        '{4,   0, 0, 1, 1, -256, 512, 1, 0},
        '{4, 127, 0, 1, 0, 0, 0, 0, 0},
        '{4,  90, 1, 0, 0, 0, 0, 0, 0},
        '{4,  45, 0, 0, 0, 0, 0, 0, 0}
    };

    t_curve_point                   expected_points [$];
    logic signed [qbt_pkg::Q_W-1:0] curve_regs [8];
    int unsigned                    fail_count   = 0;
    int unsigned                    results_seen = 0;
    int unsigned                    cycle_count  = 0;
    bit                             steady_flow  = 0;

    // Weighted sum of one axis over 2^32, rounded half up, clamped to Q15.8
    function automatic logic signed [qbt_pkg::Q_W-1:0] blend_axis(
        input longint w0, input longint w1, input longint w2,
        input logic signed [qbt_pkg::Q_W-1:0] a, input logic signed [qbt_pkg::Q_W-1:0] b,
        input logic signed [qbt_pkg::Q_W-1:0] c
    );
        longint acc;
        acc = w0 * longint'(a) + w1 * longint'(b) + w2 * longint'(c);
        acc = (acc + (longint'(1) <<< 31)) >>> 32;
        if (acc > longint'(COORD_MAX)) begin
            acc = longint'(COORD_MAX);
        end
        if (acc < longint'(COORD_MIN)) begin
            acc = longint'(COORD_MIN);
        end
        return acc[qbt_pkg::Q_W-1:0];
    endfunction

    // Curve point at t = idx / SEGMENTS plus the back-region and last-sample flags
    function automatic t_curve_point predict_point(
        input logic [qbt_pkg::IDX_W-1:0] idx, input bit lower, input bit mirr
    );
        t_curve_point                   p;
        longint                         i;
        longint                         t;
        longint                         u;
        logic signed [qbt_pkg::Q_W-1:0] ax;
        logic signed [qbt_pkg::Q_W-1:0] ay;
        i = longint'(idx);
        if (i > qbt_pkg::SEGMENTS - 1) begin
            i = qbt_pkg::SEGMENTS - 1;
        end
        t = (i * 65536 + qbt_pkg::SEGMENTS / 2) / qbt_pkg::SEGMENTS;
        if (t > 65536) begin
            t = 65536;
        end
        u = 65536 - t;
        p.x = blend_axis(u * u, 2 * u * t, t * t, curve_regs[qbt_pkg::CFG_START_X],
                         curve_regs[qbt_pkg::CFG_CTRL_X], curve_regs[qbt_pkg::CFG_END_X]);
        p.y = blend_axis(u * u, 2 * u * t, t * t, curve_regs[qbt_pkg::CFG_START_Y],
                         curve_regs[qbt_pkg::CFG_CTRL_Y], curve_regs[qbt_pkg::CFG_END_Y]);
        ax = curve_regs[qbt_pkg::CFG_APEX_X];
        ay = curve_regs[qbt_pkg::CFG_APEX_Y];
        if (lower) begin
            p.back = (p.y > ay) && (mirr ? (p.x < ax) : (p.x > ax));
        end else begin
            p.back = (p.y < ay) && (mirr ? (p.x > ax) : (p.x < ax));
        end
        p.last = (int'(idx) == qbt_pkg::SEGMENTS - 1);
        return p;
    endfunction

    // Mostly range extremes, zero and small values, the rest anywhere in range
    function automatic logic signed [qbt_pkg::Q_W-1:0] random_coord();
        int near_v;
        near_v = int'($urandom_range(0, 8191)) - 4096;
        case ($urandom_range(0, 5))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return near_v[qbt_pkg::Q_W-1:0];
            default: return qbt_pkg::Q_W'($urandom());
        endcase
    endfunction

    // Drive one register write at this falling edge and track it
    task automatic write_reg(input qbt_pkg::t_cfg_reg r,
                             input logic signed [qbt_pkg::Q_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_idx   <= r;
        cfg_wdata <= v;
        curve_regs[r] = v;
        @(negedge i_clk);
    endtask

    // Random curve; the apex is random, on the curve, or within one LSB of it
    task automatic program_random_curve();
        t_curve_point anchor;
        int           r;
        int           mode;
        int           ax;
        int           ay;
        for (r = 0; r < 6; r++) begin
            write_reg(qbt_pkg::t_cfg_reg'(r), random_coord());
        end
        mode   = int'($urandom_range(0, 2));
        anchor = predict_point(qbt_pkg::IDX_W'($urandom_range(0, 127)), 1'b0, 1'b0);
        if (mode == 0) begin
            ax = int'(random_coord());
            ay = int'(random_coord());
        end else begin
            ax = int'(anchor.x);
            ay = int'(anchor.y);
            if (mode == 2) begin
                ax = ax + int'($urandom_range(0, 2)) - 1;
                ay = ay + int'($urandom_range(0, 2)) - 1;
                ax = (ax > int'(COORD_MAX)) ? int'(COORD_MAX)
                   : ((ax < int'(COORD_MIN)) ? int'(COORD_MIN) : ax);
                ay = (ay > int'(COORD_MAX)) ? int'(COORD_MAX)
                   : ((ay < int'(COORD_MIN)) ? int'(COORD_MIN) : ay);
            end
        end
        write_reg(qbt_pkg::CFG_APEX_X, qbt_pkg::Q_W'(ax));
        write_reg(qbt_pkg::CFG_APEX_Y, qbt_pkg::Q_W'(ay));
        cfg_we <= 1'b0;
    endtask

    // Offer one request after a gap; queue its point once the transaction happens
    task automatic send_sample(
        input logic [qbt_pkg::IDX_W-1:0] idx, input bit lower, input bit mirr,
        input t_curve_point want, input int gap
    );
        if (gap > 0) begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_bus.valid        <= 1'b1;
        sample_bus.sample_index <= idx;
        sample_bus.lower_half   <= lower;
        sample_bus.mirrored     <= mirr;
        do @(posedge i_clk); while (sample_bus.ready !== 1'b1);
        expected_points.push_back(want);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every queued point has come back
    task automatic drain_points();
        sample_bus.valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Compare one output transaction against the oldest queued point
    task automatic check_point();
        t_curve_point want;
        results_seen++;
        if (expected_points.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected point, expected none, got x=%0d y=%0d back=%0b last=%0b",
                     $time, point_bus.point_x, point_bus.point_y,
                     point_bus.back_region, point_bus.last_sample);
            return;
        end
        want = expected_points.pop_front();
        if (point_bus.point_x !== want.x) begin
            fail_count++;
            $display("%0t: point_x expected %0d, got %0d", $time, want.x, point_bus.point_x);
        end
        if (point_bus.point_y !== want.y) begin
            fail_count++;
            $display("%0t: point_y expected %0d, got %0d", $time, want.y, point_bus.point_y);
        end
        if (point_bus.back_region !== want.back) begin
            fail_count++;
            $display("%0t: back_region expected %0b, got %0b", $time, want.back,
                     point_bus.back_region);
        end
        if (point_bus.last_sample !== want.last) begin
            fail_count++;
            $display("%0t: last_sample expected %0b, got %0b", $time, want.last,
                     point_bus.last_sample);
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("quad_bezier_tessellator_core_test NOT OK");
        $finish;
    end

    // Output side: random stalls, two long hold-offs to back the pipeline up
    initial begin
        int gap;
        point_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            gap = steady_flow ? 0 : int'($urandom_range(0, 5));
            if (results_seen == 500 || results_seen == 1300) begin
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                point_bus.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            point_bus.ready <= 1'b1;
            do @(posedge i_clk); while (point_bus.valid !== 1'b1);
            check_point();
        end
    end

    // Stimulus: reset, directed table, random phases, final drain
    initial begin
        t_curve_point              want;
        logic [qbt_pkg::IDX_W-1:0] idx;
        bit                        lo;
        bit                        mi;
        int                        r;
        int                        ph;
        int                        k;
        int                        active_set;

        i_rst_n                 = 1'b0;
        cfg_we                  = 1'b0;
        cfg_idx                 = '0;
        cfg_wdata               = '0;
        sample_bus.valid        = 1'b0;
        sample_bus.sample_index = '0;
        sample_bus.lower_half   = 1'b0;
        sample_bus.mirrored     = 1'b0;
        for (r = 0; r < 8; r++) begin
            curve_regs[r] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        active_set = 0;

        // Directed rows; reload registers whenever the row's set changes
        foreach (sample_rows[n]) begin
            if (sample_rows[n].cfg_set != active_set) begin
                drain_points();
                active_set = sample_rows[n].cfg_set;
                for (r = 0; r < 8; r++) begin
                    write_reg(qbt_pkg::t_cfg_reg'(r), curve_sets[active_set][r]);
                end
                cfg_we <= 1'b0;
            end
            if (sample_rows[n].typed) begin
                want.x    = sample_rows[n].x;
                want.y    = sample_rows[n].y;
                want.back = sample_rows[n].back;
                want.last = sample_rows[n].last;
            end else begin
                want = predict_point(sample_rows[n].idx, sample_rows[n].lower,
                                     sample_rows[n].mirr);
            end
            send_sample(sample_rows[n].idx, sample_rows[n].lower, sample_rows[n].mirr,
                        want, int'($urandom_range(0, 5)));
        end

        // Random phases, each on a fresh curve; some phases run without gaps
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_points();
            program_random_curve();
            steady_flow = (ph % 4 == 1);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(0, 9))
                    0: idx = '0;
                    1: idx = qbt_pkg::IDX_W'(qbt_pkg::SEGMENTS - 1);
                    default: idx = qbt_pkg::IDX_W'($urandom_range(0, qbt_pkg::IDX_DEPTH - 1));
                endcase
                lo = 1'($urandom_range(0, 1));
                mi = 1'($urandom_range(0, 1));
                send_sample(idx, lo, mi, predict_point(idx, lo, mi),
                            steady_flow ? 0 : int'($urandom_range(0, 5)));
            end
        end

        drain_points();
        steady_flow = 0;
        repeat (12) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("quad_bezier_tessellator_core_test OK");
        end else begin
            $display("quad_bezier_tessellator_core_test NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
rtl/qbt_pkg.sv
rtl/qbt_in_if.sv
rtl/qbt_out_if.sv
rtl/qbt_axis.sv
rtl/quad_bezier_tessellator_core.sv
test/quad_bezier_tessellator_core_test.sv
